// ----- rtl/core/ukt_pkg.sv -----
// shared types, codes and constants of the unique key table
package ukt_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 31;
    localparam int REQ_W    = 32;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // default number of table entries
    localparam int CAPACITY_DEFAULT = 64;

    // depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // command codes on the cmd port
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

    // status codes on the status port
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MEM_ERR   = 3'd4;

    // decoded operation
    typedef enum logic [1:0] {
        OP_FIND,
        OP_INSERT,
        OP_ERASE,
        OP_NOP
    } op_t;

    // classified request as it sits in the queue
    typedef struct packed {
        op_t               op;
        logic              key_ok;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    // back end sequencer
    typedef enum logic {
        BK_CMP,
        BK_EXEC
    } back_state_t;

endpackage

// ----- rtl/core/unique_key_table_top.sv -----
// top level of the unique key table
//
//  port group                          dir   transfer
//  start, busy, cmd/req_key/req_value  in    at a clock edge with start high and busy low
//  done, status, found_value           out   one cycle with done high, no back pressure
//
// a request goes from the queue through the compare and result registers to done; the
// table engine runs compare then execute per request and pops the next only after execute
// a two-entry request queue takes new requests while the engine works; busy is
// high only when that queue is full
// reset empties the table at once, no clearing pass; results cannot be stalled
module unique_key_table_top #(
    parameter int CAPACITY = ukt_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [ukt_pkg::CMD_W-1:0]    cmd,
    input  logic signed [ukt_pkg::REQ_W-1:0]    req_key,
    input  logic signed [ukt_pkg::DATA_W-1:0]   req_value,
    output logic                                done,
    output logic        [ukt_pkg::STATUS_W-1:0] status,
    output logic signed [ukt_pkg::DATA_W-1:0]   found_value
);
    import ukt_pkg::*;

    logic   pop;
    logic   q_valid;
    req_t   q_req;

    // intake and request queue
    ukt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .req_key   (req_key),
        .req_value (req_value),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_req     (q_req)
    );

    // table engine
    ukt_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_req       (q_req),
        .pop         (pop),
        .done        (done),
        .status      (status),
        .found_value (found_value)
    );

endmodule

// ----- rtl/core/ukt_front.sv -----
// request intake: command decode, key check and the request queue
module ukt_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [ukt_pkg::CMD_W-1:0]    cmd,
    input  logic signed [ukt_pkg::REQ_W-1:0]    req_key,
    input  logic signed [ukt_pkg::DATA_W-1:0]   req_value,
    input  logic                                pop,
    output logic                                q_valid,
    output ukt_pkg::req_t                       q_req
);
    import ukt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    req_t               queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pull;
    req_t               req_in;

    // classify the incoming request
    always_comb
    begin
        req_in.key_ok = (req_key != '0) && !req_key[REQ_W-1];
        req_in.key    = req_key[KEY_W-1:0];
        req_in.value  = req_value;
        case (cmd)
            CMD_FIND:   req_in.op = OP_FIND;
            CMD_INSERT: req_in.op = OP_INSERT;
            CMD_ERASE:  req_in.op = OP_ERASE;
            default:    req_in.op = OP_NOP;
        endcase
    end

    // queue handshake
    assign busy    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign pull    = pop && q_valid;
    assign q_req   = queue_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pull)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pull)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pull && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= req_in;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("request queue overfilled");

    // an accepted request shows up in the queue
    a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("accepted request not queued");

    // a pull and no push lowers the count by one
    a_pull_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pull && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count lost track of a pull");

endmodule

// ----- rtl/core/ukt_back.sv -----
// table engine: parallel key compare, entry store and result register
module ukt_back #(
    parameter int CAPACITY = ukt_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  ukt_pkg::req_t                       q_req,
    output logic                                pop,
    output logic                                done,
    output logic        [ukt_pkg::STATUS_W-1:0] status,
    output logic signed [ukt_pkg::DATA_W-1:0]   found_value
);
    import ukt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic                   exec_en;

    logic [CAPACITY-1:0]    valid_reg;
    logic [KEY_W-1:0]       cam_key_reg [CAPACITY];
    logic [DATA_W-1:0]      value_mem [CAPACITY];
    logic [DATA_W-1:0]      rd_data_reg;

    logic [CAPACITY-1:0]    match;
    logic [CAPACITY-1:0]    free_oh;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       free_idx;

    req_t                   req_reg;
    logic                   hit_reg;
    logic                   full_reg;
    logic                   empty_reg;
    logic [IDX_W-1:0]       match_idx_reg;
    logic [IDX_W-1:0]       free_idx_reg;

    logic [STATUS_W-1:0]    status_next;
    logic                   ins_en;
    logic                   ers_en;
    logic                   rd_en;

    logic                   done_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic                   sel_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CMP:
            begin
                if (q_valid)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: state_next = BK_CMP;
            default: state_next = BK_CMP;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop     = 1'b0;
        exec_en = 1'b0;
        case (state_reg)
            BK_CMP:  pop = q_valid;
            BK_EXEC: exec_en = 1'b1;
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CMP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // key compare over every entry and lowest free entry
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        free_oh   = ~valid_reg & (valid_reg + CAPACITY'(1));
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = valid_reg[i] && (cam_key_reg[i] == q_req.key);
            if (match[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (free_oh[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    // compare results held for the execute cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            req_reg       <= q_req;
            hit_reg       <= |match;
            full_reg      <= &valid_reg;
            empty_reg     <= ~|valid_reg;
            match_idx_reg <= match_idx;
            free_idx_reg  <= free_idx;
        end
    end

    // execute: status and table actions
    always_comb
    begin
        status_next = ST_OK;
        ins_en      = 1'b0;
        ers_en      = 1'b0;
        rd_en       = 1'b0;
        case (req_reg.op)
            OP_FIND:
            begin
                if (req_reg.key_ok && hit_reg)
                begin
                    rd_en = exec_en;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_INSERT:
            begin
                if (!req_reg.key_ok)
                begin
                    status_next = ST_BAD_KEY;
                end
                else if (full_reg)
                begin
                    status_next = ST_MEM_ERR;
                end
                else if (hit_reg)
                begin
                    status_next = ST_EXISTS;
                end
                else
                begin
                    ins_en = exec_en;
                end
            end
            OP_ERASE:
            begin
                if (empty_reg)
                begin
                    status_next = ST_MEM_ERR;
                end
                else if (!req_reg.key_ok)
                begin
                    status_next = ST_BAD_KEY;
                end
                else if (hit_reg)
                begin
                    ers_en = exec_en;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    // entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ins_en)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
            end
            if (ers_en)
            begin
                valid_reg[match_idx_reg] <= 1'b0;
            end
        end
    end

    // key cells
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            cam_key_reg[free_idx_reg] <= req_reg.key;
        end
    end

    // value store, registered read
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            value_mem[free_idx_reg] <= req_reg.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= value_mem[match_idx_reg];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            status_reg <= status_next;
            sel_reg    <= rd_en;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = sel_reg ? rd_data_reg : '0;

    // keys stay unique, so at most one entry matches
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> $onehot0(match))
        else $error("more than one entry matched a key");

    // a stored insert grows the table by one entry
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("insert did not add one entry");

    // a successful erase shrinks the table by one entry
    a_erase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ers_en |=> $countones(valid_reg) + 1 == $past($countones(valid_reg)))
        else $error("erase did not remove one entry");

    // a value is only returned with an ok status
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> found_value == '0)
        else $error("value returned with an error status");

    // results are never back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

endmodule

// ----- tb/tb_unique_key_table_top.sv -----
// testbench for the unique key table: directed and random requests checked against a shadow table
`timescale 1ns / 1ps

module tb_unique_key_table_top;
    import ukt_pkg::*;

    localparam int CAPACITY = CAPACITY_DEFAULT;
    localparam int KEY_POOL_SIZE = 96;
    // the fourth command code has no name in the package and must change nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
    } reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [CMD_W-1:0]           cmd = CMD_FIND;
    logic signed [REQ_W-1:0]    req_key = '0;
    logic signed [DATA_W-1:0]   req_value = '0;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   found_value;

    // shadow copy of the table contents
    logic                       shadow_valid [CAPACITY];
    logic [KEY_W-1:0]           shadow_key   [CAPACITY];
    logic signed [DATA_W-1:0]   shadow_value [CAPACITY];

    reply_t                     expected_replies [$];
    reply_t                     oldest_reply;
    logic signed [REQ_W-1:0]    key_pool [KEY_POOL_SIZE];
    int                         error_count = 0;

    unique_key_table_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .req_key     (req_key),
        .req_value   (req_value),
        .done        (done),
        .status      (status),
        .found_value (found_value)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // number of occupied entries in the shadow table
    function automatic int entries_in_use();
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++)
            if (shadow_valid[i])
                n++;
        return n;
    endfunction

    // apply one request to the shadow table and return the reply it should give
    function automatic reply_t apply_request(logic [CMD_W-1:0] c, logic signed [REQ_W-1:0] k,
                                             logic signed [DATA_W-1:0] v);
        reply_t r;
        logic   key_ok;
        int     hit;
        int     free_idx;
        int     used;
        r.status = ST_OK;
        r.value  = '0;
        key_ok   = (k > 0);
        hit      = -1;
        free_idx = -1;
        used     = 0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (shadow_valid[i])
            begin
                used++;
                if (hit < 0 && key_ok && shadow_key[i] == k[KEY_W-1:0])
                    hit = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        case (c)
            CMD_FIND:
            begin
                if (hit >= 0)
                    r.value = shadow_value[hit];
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_INSERT:
            begin
                // full table wins over a duplicate key
                if (!key_ok)
                    r.status = ST_BAD_KEY;
                else if (free_idx < 0)
                    r.status = ST_MEM_ERR;
                else if (hit >= 0)
                    r.status = ST_EXISTS;
                else
                begin
                    shadow_valid[free_idx] = 1'b1;
                    shadow_key[free_idx]   = k[KEY_W-1:0];
                    shadow_value[free_idx] = v;
                end
            end
            CMD_ERASE:
            begin
                // empty table wins over a bad key
                if (used == 0)
                    r.status = ST_MEM_ERR;
                else if (!key_ok)
                    r.status = ST_BAD_KEY;
                else if (hit >= 0)
                    shadow_valid[hit] = 1'b0;
                else
                    r.status = ST_NOT_FOUND;
            end
            default: ;
        endcase
        return r;
    endfunction

    // random positive key over the whole legal range
    function automatic logic signed [REQ_W-1:0] fresh_key();
        return ($urandom % 32'h7fff_ffff) + 1;
    endfunction

    // random occupied slot, -1 when the table is empty
    function automatic int random_entry();
        int first;
        int idx;
        first = $urandom_range(CAPACITY - 1);
        for (int i = 0; i < CAPACITY; i++)
        begin
            idx = (first + i) % CAPACITY;
            if (shadow_valid[idx])
                return idx;
        end
        return -1;
    endfunction

    // key mix: mostly a small pool so requests hit, plus illegal and wide keys
    function automatic logic signed [REQ_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        else if (sel < 78)
            return '0;
        else if (sel < 82)
            return 32'sh8000_0000;
        else if (sel < 90)
            return {1'b1, 31'($urandom)};
        else
            return $urandom;
    endfunction

    // value mix with the extremes
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // one request transfer, then an optional sender gap
    task automatic send_req(input logic [CMD_W-1:0] c, input logic signed [REQ_W-1:0] k,
                            input logic signed [DATA_W-1:0] v, input int idle_pct);
        start     <= 1'b1;
        cmd       <= c;
        req_key   <= k;
        req_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_replies.push_back(apply_request(c, k, v));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // hold off the sender until every reply is back
    task automatic wait_all_replies();
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // requests on an empty table
    task automatic test_empty_table();
        send_req(CMD_ERASE, 32'sd5, 32'sd7, 0);
        send_req(CMD_ERASE, '0, '0, 0);
        send_req(CMD_ERASE, 32'sh8000_0000, -1, 0);
        send_req(CMD_FIND, 32'sd1, '0, 0);
        send_req(CMD_UNUSED, 32'sd1, 32'sh1234_5678, 0);
    endtask

    // non-positive keys
    task automatic test_key_checks();
        send_req(CMD_INSERT, '0, 32'sd1, 0);
        send_req(CMD_INSERT, 32'sh8000_0000, 32'sd1, 0);
        send_req(CMD_INSERT, -1, 32'sd1, 0);
        send_req(CMD_FIND, '0, '0, 0);
        send_req(CMD_FIND, 32'sh8000_0000, '0, 0);
    endtask

    // insert, duplicate, find, erase with extreme keys and values
    task automatic test_basic_ops();
        send_req(CMD_INSERT, 32'sd1, 32'sh7fff_ffff, 0);
        send_req(CMD_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 0);
        send_req(CMD_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa, 0);
        send_req(CMD_INSERT, 32'sh2aaa_aaaa, 32'sh5555_5555, 0);
        send_req(CMD_INSERT, 32'sd1, 32'sd99, 0);
        send_req(CMD_FIND, 32'sd1, 32'sd3, 0);
        send_req(CMD_FIND, 32'sh7fff_ffff, '0, 0);
        send_req(CMD_FIND, 32'sh5555_5555, '0, 0);
        send_req(CMD_FIND, 32'sd2, '0, 0);
        // negative key whose low bits match a stored key
        send_req(CMD_FIND, 32'shd555_5555, '0, 0);
        send_req(CMD_ERASE, '0, '0, 0);
        send_req(CMD_ERASE, 32'shffff_ffff, '0, 0);
        send_req(CMD_ERASE, 32'sd2, '0, 0);
        send_req(CMD_ERASE, 32'sd1, '0, 0);
        send_req(CMD_FIND, 32'sd1, '0, 0);
        send_req(CMD_UNUSED, 32'sh7fff_ffff, -1, 0);
        send_req(CMD_INSERT, 32'sd1, '0, 0);
    endtask

    // fill to capacity, hit the full table, then erase everything
    task automatic test_fill_and_drain(input int idle_pct);
        int guard;
        int idx;
        guard = 0;
        while (entries_in_use() < CAPACITY && guard < 4 * CAPACITY)
        begin
            send_req(CMD_INSERT, fresh_key(), pick_value(), idle_pct);
            guard++;
        end
        // duplicate and new key both get a memory error on a full table
        idx = random_entry();
        send_req(CMD_INSERT, {1'b0, shadow_key[idx]}, pick_value(), idle_pct);
        send_req(CMD_INSERT, fresh_key(), pick_value(), idle_pct);
        send_req(CMD_FIND, {1'b0, shadow_key[idx]}, pick_value(), idle_pct);
        send_req(CMD_ERASE, {1'b0, shadow_key[idx]}, pick_value(), idle_pct);
        send_req(CMD_INSERT, fresh_key(), pick_value(), idle_pct);
        // erase in random order, sometimes looking the key up again
        idx = random_entry();
        while (idx >= 0)
        begin
            send_req(CMD_ERASE, {1'b0, shadow_key[idx]}, pick_value(), idle_pct);
            if ($urandom_range(3) == 0)
                send_req(CMD_FIND, {1'b0, shadow_key[idx]}, pick_value(), idle_pct);
            idx = random_entry();
        end
        send_req(CMD_ERASE, fresh_key(), pick_value(), idle_pct);
    endtask

    // random mix of requests with the given weights
    task automatic run_mixed_phase(input int n_items, input int idle_pct,
                                   input int insert_pct, input int erase_pct);
        int                      sel;
        int                      idx;
        logic [CMD_W-1:0]        c;
        logic signed [REQ_W-1:0] k;
        for (int n = 0; n < n_items; n++)
        begin
            sel = $urandom_range(99);
            if (sel < insert_pct)
                c = CMD_INSERT;
            else if (sel < insert_pct + erase_pct)
                c = CMD_ERASE;
            else if (sel < 97)
                c = CMD_FIND;
            else
                c = CMD_UNUSED;
            k = pick_key();
            idx = random_entry();
            if (idx >= 0 && $urandom_range(99) < 30)
                k = {1'b0, shadow_key[idx]};
            send_req(c, k, pick_value(), idle_pct);
        end
    endtask

    // compare each result with the oldest expected reply
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result with nothing expected: status %0d found_value %0d",
                       status, found_value);
                error_count++;
            end
            else
            begin
                oldest_reply = expected_replies.pop_front();
                if (status !== oldest_reply.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_reply.status, status);
                    error_count++;
                end
                if (found_value !== oldest_reply.value)
                begin
                    $error("found_value: expected %0d, actual %0d",
                           oldest_reply.value, found_value);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
            shadow_valid[i] = 1'b0;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = fresh_key();
        key_pool[0] = 32'sd1;
        key_pool[1] = 32'sh7fff_ffff;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_key_checks();
        test_basic_ops();
        test_fill_and_drain(53);
        wait_all_replies();
        run_mixed_phase(350, 0, 55, 20);
        wait_all_replies();
        run_mixed_phase(350, 53, 35, 35);
        run_mixed_phase(350, 34, 60, 15);
        wait_all_replies();
        run_mixed_phase(350, 0, 30, 45);
        test_fill_and_drain(34);

        // let the last replies come back
        wait_all_replies();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("[unique_key_table_top] OK");
        else
            $display("[unique_key_table_top] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("[unique_key_table_top] ERROR");
        $finish;
    end

endmodule
